### design/dgm_pkg.sv
package dgm_pkg;

   // candidate pairs evaluated per pixel
   localparam int NUM_PAIRS = 13;

   // configuration register indexes
   localparam logic [2:0] REG_LIMIT0    = 3'd0;
   localparam logic [2:0] REG_LIMIT1    = 3'd1;
   localparam logic [2:0] REG_LIMIT2    = 3'd2;
   localparam logic [2:0] REG_MODE0     = 3'd3;
   localparam logic [2:0] REG_MODE1     = 3'd4;
   localparam logic [2:0] REG_MODE2     = 3'd5;
   localparam logic [2:0] REG_SKIP      = 3'd6;
   localparam logic [2:0] REG_BIT_DEPTH = 3'd7;

   // selection rules
   localparam logic [2:0] MODE_MIN_DIFF  = 3'd0;
   localparam logic [2:0] MODE_DIFF_X4   = 3'd1;
   localparam logic [2:0] MODE_DIFF_X2   = 3'd2;
   localparam logic [2:0] MODE_DIFF_X1   = 3'd3;
   localparam logic [2:0] MODE_DIST_X2   = 3'd4;
   localparam logic [2:0] MODE_DIST_ONLY = 3'd5;

   // plane code with no register set
   localparam logic [1:0] PLANE_NONE = 2'd3;

   // register reset values
   localparam logic [7:0] LIMIT_RESET     = 8'd4;
   localparam logic [2:0] MODE_RESET      = MODE_DIFF_X4;
   localparam logic [4:0] BIT_DEPTH_RESET = 5'd8;
   localparam logic [4:0] BIT_DEPTH_MIN   = 5'd8;

   // floor(x / 255) for x below 2^24: (x * 32897) >> 23 is exact or one high
   localparam int LIMIT_SCALE  = 255;
   localparam logic [15:0] RECIP = 16'd32897;
   localparam int RECIP_SHIFT  = 23;

   // pixel sources: previous 0..8, current 9..17, next 18..26 (row major)
   localparam int NUM_SRC = 27;
   localparam int CENTER_SRC = 13;

   // pair order for the min-diff rule: temporal pairs first
   localparam logic [4:0] PAIR_A_MIN [NUM_PAIRS] = '{
      5'd18, 5'd20, 5'd24, 5'd26, 5'd25, 5'd19, 5'd21, 5'd23, 5'd22,
      5'd9, 5'd11, 5'd10, 5'd12};
   localparam logic [4:0] PAIR_B_MIN [NUM_PAIRS] = '{
      5'd8, 5'd6, 5'd2, 5'd0, 5'd1, 5'd7, 5'd5, 5'd3, 5'd4,
      5'd17, 5'd15, 5'd16, 5'd14};
   // pair order for the weighted rules: spatial pairs first
   localparam logic [4:0] PAIR_A_WGT [NUM_PAIRS] = '{
      5'd9, 5'd15, 5'd16, 5'd14,
      5'd18, 5'd20, 5'd24, 5'd26, 5'd25, 5'd19, 5'd21, 5'd23, 5'd22};
   localparam logic [4:0] PAIR_B_WGT [NUM_PAIRS] = '{
      5'd17, 5'd11, 5'd10, 5'd12,
      5'd8, 5'd6, 5'd2, 5'd0, 5'd1, 5'd7, 5'd5, 5'd3, 5'd4};

   // position of the current left/right pair in each order
   localparam int HPAIR_MIN = 12;
   localparam int HPAIR_WGT = 3;

   typedef struct packed {
      logic       bypass;
      logic [2:0] mode;
   } ctrl_type;

endpackage

### design/dgm_prep.sv
module dgm_prep #(
   parameter int PIXEL_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  logic [8:0][47:0]       in_win,
   input  logic [1:0]             in_plane,
   input  logic                   in_copy,
   input  logic [2:0][7:0]        cfg_limit,
   input  logic [2:0][2:0]        cfg_mode,
   input  logic                   cfg_skip,
   input  logic [4:0]             cfg_bit_depth,
   output logic                   out_valid,
   input  logic                   out_ready,
   output dgm_pkg::ctrl_type      out_ctrl,
   output logic [PIXEL_BITS-1:0]  out_c,
   output logic [PIXEL_BITS-1:0]  out_pmax,
   output logic [PIXEL_BITS-1:0]  out_lim,
   output logic [dgm_pkg::NUM_PAIRS-1:0][PIXEL_BITS-1:0] out_pa,
   output logic [dgm_pkg::NUM_PAIRS-1:0][PIXEL_BITS-1:0] out_pb,
   output logic [dgm_pkg::NUM_PAIRS-1:0] out_en
);

   localparam int W  = PIXEL_BITS;
   localparam int NP = dgm_pkg::NUM_PAIRS;
   localparam int XW = W + 8;
   localparam int PW = XW + 16;

   typedef struct packed {
      dgm_pkg::ctrl_type       ctrl;
      logic [W-1:0]            c;
      logic [W-1:0]            pmax;
      logic [NP-1:0][W-1:0]    pa;
      logic [NP-1:0][W-1:0]    pb;
      logic [NP-1:0]           en;
   } carry_type;

   logic [4:0]    bd;
   logic [W-1:0]  pmax;
   logic [W-1:0]  pix [dgm_pkg::NUM_SRC];
   logic          plane_ok;
   logic [1:0]    plane_sel;
   logic [2:0]    mode_sel;
   logic [7:0]    limit_sel;
   logic          min_order;
   carry_type     s0_in;
   logic [XW-1:0] x_in;

   carry_type     s0_ff, s1_ff, s2_ff;
   logic [XW-1:0] s0_x_ff, s1_x_ff;
   logic [W:0]    s1_q_ff;
   logic [W-1:0]  s2_lim_ff;
   logic          s0_valid_ff, s1_valid_ff, s2_valid_ff;
   logic          s0_ready, s1_ready, s2_ready;

   logic [PW-1:0] prod;
   logic [W:0]    q_in;
   logic [W+8:0]  back;
   logic [W:0]    lim_wide;

   // unpack, mask to the bit depth, pick the pairs in rule order
   always_comb begin
      bd = cfg_bit_depth;
      if (bd < dgm_pkg::BIT_DEPTH_MIN) begin
         bd = dgm_pkg::BIT_DEPTH_MIN;
      end else if (bd > 5'(PIXEL_BITS)) begin
         bd = 5'(PIXEL_BITS);
      end
      for (int i = 0; i < W; i++) begin
         pmax[i] = 5'(i) < bd;
      end
      for (int f = 0; f < 3; f++) begin
         for (int r = 0; r < 3; r++) begin
            for (int k = 0; k < 3; k++) begin
               pix[f*9 + r*3 + k] = in_win[f*3 + r][32 - 16*k +: W] & pmax;
            end
         end
      end
      plane_ok  = in_plane != dgm_pkg::PLANE_NONE;
      plane_sel = plane_ok ? in_plane : 2'd0;
      mode_sel  = cfg_mode[plane_sel];
      limit_sel = cfg_limit[plane_sel];
      min_order = mode_sel == dgm_pkg::MODE_MIN_DIFF;

      s0_in.ctrl.bypass = in_copy || !plane_ok || (mode_sel > dgm_pkg::MODE_DIST_ONLY);
      s0_in.ctrl.mode   = mode_sel;
      s0_in.c           = pix[dgm_pkg::CENTER_SRC];
      s0_in.pmax        = pmax;
      for (int k = 0; k < NP; k++) begin
         s0_in.pa[k] = min_order ? pix[dgm_pkg::PAIR_A_MIN[k]] : pix[dgm_pkg::PAIR_A_WGT[k]];
         s0_in.pb[k] = min_order ? pix[dgm_pkg::PAIR_B_MIN[k]] : pix[dgm_pkg::PAIR_B_WGT[k]];
         s0_in.en[k] = !(cfg_skip &&
                         (k == (min_order ? dgm_pkg::HPAIR_MIN : dgm_pkg::HPAIR_WGT)));
      end
      x_in = XW'(pmax) * XW'(limit_sel);
   end

   // limit divide by 255: reciprocal estimate, then one-step correction
   always_comb begin
      prod     = PW'(s0_x_ff) * PW'(dgm_pkg::RECIP);
      q_in     = prod[dgm_pkg::RECIP_SHIFT +: W+1];
      back     = {s1_q_ff, 8'd0} - {8'd0, s1_q_ff};
      lim_wide = (back > (W+9)'(s1_x_ff)) ? s1_q_ff - 1'b1 : s1_q_ff;
   end

   assign s2_ready = !s2_valid_ff || out_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign s0_ready = !s0_valid_ff || s1_ready;
   assign in_ready = s0_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (s0_ready) begin
            s0_valid_ff <= in_valid;
         end
         if (s1_ready) begin
            s1_valid_ff <= s0_valid_ff;
         end
         if (s2_ready) begin
            s2_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s0_ready && in_valid) begin
         s0_ff   <= s0_in;
         s0_x_ff <= x_in;
      end
      if (s1_ready && s0_valid_ff) begin
         s1_ff   <= s0_ff;
         s1_x_ff <= s0_x_ff;
         s1_q_ff <= q_in;
      end
      if (s2_ready && s1_valid_ff) begin
         s2_ff     <= s1_ff;
         s2_lim_ff <= lim_wide[W-1:0];
      end
   end

   assign out_valid = s2_valid_ff;
   assign out_ctrl  = s2_ff.ctrl;
   assign out_c     = s2_ff.c;
   assign out_pmax  = s2_ff.pmax;
   assign out_lim   = s2_lim_ff;
   assign out_pa    = s2_ff.pa;
   assign out_pb    = s2_ff.pb;
   assign out_en    = s2_ff.en;

endmodule

### design/dgm_cell.sv
module dgm_cell #(
   parameter int PIXEL_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  dgm_pkg::ctrl_type      in_ctrl,
   input  logic [PIXEL_BITS-1:0]  in_c,
   input  logic [PIXEL_BITS-1:0]  in_pmax,
   input  logic [PIXEL_BITS-1:0]  in_lim,
   input  logic [dgm_pkg::NUM_PAIRS-1:0][PIXEL_BITS-1:0] in_pa,
   input  logic [dgm_pkg::NUM_PAIRS-1:0][PIXEL_BITS-1:0] in_pb,
   input  logic [dgm_pkg::NUM_PAIRS-1:0] in_en,
   input  logic [PIXEL_BITS-1:0]  in_best,
   input  logic [PIXEL_BITS-1:0]  in_res,
   output logic                   out_valid,
   input  logic                   out_ready,
   output dgm_pkg::ctrl_type      out_ctrl,
   output logic [PIXEL_BITS-1:0]  out_c,
   output logic [PIXEL_BITS-1:0]  out_pmax,
   output logic [PIXEL_BITS-1:0]  out_lim,
   output logic [dgm_pkg::NUM_PAIRS-1:0][PIXEL_BITS-1:0] out_pa,
   output logic [dgm_pkg::NUM_PAIRS-1:0][PIXEL_BITS-1:0] out_pb,
   output logic [dgm_pkg::NUM_PAIRS-1:0] out_en,
   output logic [PIXEL_BITS-1:0]  out_best,
   output logic [PIXEL_BITS-1:0]  out_res
);

   localparam int W  = PIXEL_BITS;
   localparam int NP = dgm_pkg::NUM_PAIRS;
   localparam int SW = W + 3;

   logic [W-1:0]  hi, lo, val, excess, d, score;
   logic [SW-1:0] sum;
   logic          take;

   dgm_pkg::ctrl_type    ctrl_ff;
   logic [W-1:0]         c_ff, pmax_ff, lim_ff, best_ff, res_ff;
   logic [NP-1:0][W-1:0] pa_ff, pb_ff;
   logic [NP-1:0]        en_ff;
   logic                 valid_ff;

   // score the pair at the head of the list
   always_comb begin
      hi   = (in_pa[0] > in_pb[0]) ? in_pa[0] : in_pb[0];
      lo   = (in_pa[0] > in_pb[0]) ? in_pb[0] : in_pa[0];
      d    = hi - lo;
      if (in_c < lo) begin
         val    = lo;
         excess = lo - in_c;
      end else if (in_c > hi) begin
         val    = hi;
         excess = in_c - hi;
      end else begin
         val    = in_c;
         excess = '0;
      end
      case (in_ctrl.mode)
         dgm_pkg::MODE_DIFF_X4: sum = SW'(excess) + SW'({d, 2'b00});
         dgm_pkg::MODE_DIFF_X2: sum = SW'(excess) + SW'({d, 1'b0});
         dgm_pkg::MODE_DIFF_X1: sum = SW'(excess) + SW'(d);
         dgm_pkg::MODE_DIST_X2: sum = SW'({excess, 1'b0}) + SW'(d);
         default:               sum = SW'(d);
      endcase
      if (in_ctrl.mode == dgm_pkg::MODE_MIN_DIFF) begin
         score = d;
      end else if (in_ctrl.mode == dgm_pkg::MODE_DIST_ONLY) begin
         score = excess;
      end else if (sum > SW'(in_pmax)) begin
         score = in_pmax;
      end else begin
         score = sum[W-1:0];
      end
      // equal scores go to the later pair
      take = in_en[0] && (score <= in_best);
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         ctrl_ff <= in_ctrl;
         c_ff    <= in_c;
         pmax_ff <= in_pmax;
         lim_ff  <= in_lim;
         pa_ff   <= {{W{1'b0}}, in_pa[NP-1:1]};
         pb_ff   <= {{W{1'b0}}, in_pb[NP-1:1]};
         en_ff   <= {1'b0, in_en[NP-1:1]};
         best_ff <= take ? score : in_best;
         res_ff  <= take ? val : in_res;
      end
   end

   assign out_valid = valid_ff;
   assign out_ctrl  = ctrl_ff;
   assign out_c     = c_ff;
   assign out_pmax  = pmax_ff;
   assign out_lim   = lim_ff;
   assign out_pa    = pa_ff;
   assign out_pb    = pb_ff;
   assign out_en    = en_ff;
   assign out_best  = best_ff;
   assign out_res   = res_ff;

endmodule

### design/spatiotemporal_degrain_pixel_top.sv
// spatio-temporal degrain filter, one pixel per word. each request word carries the 3x3
// windows of the previous, current and next frame plus a plane select and a border
// copy flag; the response word is the filtered pixel. a new word is taken every clock
// while the response side does not stall. each word passes through the setup stages
// (unpack and mask, limit multiply, divide-by-255 correction), the 13 cells of the
// pair chain, each scoring one candidate pair and handing its running best to the
// next, and the output register. planes and rules are set through the csr port,
// which accepts a write every cycle; write it only with no pixels in flight. there is
// no state between pixels and no start-up sweep after reset.
module spatiotemporal_degrain_pixel_top #(
   parameter int PIXEL_BITS = 16
) (
   input  logic         clock,
   input  logic         reset,
   // request words
   input  logic         req_tvalid,
   output logic         req_tready,
   // prev_top, prev_mid, prev_bot, cur_top, cur_mid, cur_bot,
   // next_top, next_mid, next_bot (48 bits each)
   input  logic [431:0] req_tdata,
   // plane_index [1:0], copy_through [2]
   input  logic [2:0]   req_tuser,
   // response words
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // out_pixel [15:0]
   output logic [15:0]  rsp_tdata,
   // register writes
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [2:0]   csr_index,
   input  logic [7:0]   csr_data
);

   localparam int W  = PIXEL_BITS;
   localparam int NP = dgm_pkg::NUM_PAIRS;

   // configuration registers
   logic [2:0][7:0] limit_ff;
   logic [2:0][2:0] mode_ff;
   logic            skip_ff;
   logic [4:0]      bit_depth_ff;

   // pair chain links, link 0 from setup, link NP into the output stage
   logic                 chain_valid [NP+1];
   logic                 chain_ready [NP+1];
   dgm_pkg::ctrl_type    chain_ctrl  [NP+1];
   logic [W-1:0]         chain_c     [NP+1];
   logic [W-1:0]         chain_pmax  [NP+1];
   logic [W-1:0]         chain_lim   [NP+1];
   logic [W-1:0]         chain_best  [NP+1];
   logic [W-1:0]         chain_res   [NP+1];
   logic [NP-1:0][W-1:0] chain_pa    [NP+1];
   logic [NP-1:0][W-1:0] chain_pb    [NP+1];
   logic [NP-1:0]        chain_en    [NP+1];

   // output stage
   logic         out_ready;
   logic [W-1:0] lo_b, hi_b, clamped, pixel_in;
   logic [W:0]   up_sum;
   logic         rsp_tvalid_ff;
   logic [W-1:0] out_pixel_ff, out_pmax_ff, out_c_ff;
   logic         out_bypass_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= {3{dgm_pkg::LIMIT_RESET}};
         mode_ff      <= {3{dgm_pkg::MODE_RESET}};
         skip_ff      <= 1'b0;
         bit_depth_ff <= dgm_pkg::BIT_DEPTH_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            dgm_pkg::REG_LIMIT0:    limit_ff[0]  <= csr_data;
            dgm_pkg::REG_LIMIT1:    limit_ff[1]  <= csr_data;
            dgm_pkg::REG_LIMIT2:    limit_ff[2]  <= csr_data;
            dgm_pkg::REG_MODE0:     mode_ff[0]   <= csr_data[2:0];
            dgm_pkg::REG_MODE1:     mode_ff[1]   <= csr_data[2:0];
            dgm_pkg::REG_MODE2:     mode_ff[2]   <= csr_data[2:0];
            dgm_pkg::REG_SKIP:      skip_ff      <= csr_data[0];
            dgm_pkg::REG_BIT_DEPTH: bit_depth_ff <= csr_data[4:0];
            default: ;
         endcase
      end
   end

   // setup: unpack windows, order the pairs, work out the limit
   dgm_prep #(
      .PIXEL_BITS (PIXEL_BITS)
   ) u_prep (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (req_tvalid),
      .in_ready      (req_tready),
      .in_win        (req_tdata),
      .in_plane      (req_tuser[1:0]),
      .in_copy       (req_tuser[2]),
      .cfg_limit     (limit_ff),
      .cfg_mode      (mode_ff),
      .cfg_skip      (skip_ff),
      .cfg_bit_depth (bit_depth_ff),
      .out_valid     (chain_valid[0]),
      .out_ready     (chain_ready[0]),
      .out_ctrl      (chain_ctrl[0]),
      .out_c         (chain_c[0]),
      .out_pmax      (chain_pmax[0]),
      .out_lim       (chain_lim[0]),
      .out_pa        (chain_pa[0]),
      .out_pb        (chain_pb[0]),
      .out_en        (chain_en[0])
   );

   // the first enabled pair always wins against an all-ones start
   assign chain_best[0] = '1;
   assign chain_res[0]  = '0;

   for (genvar g = 0; g < NP; g++) begin : g_cell
      dgm_cell #(
         .PIXEL_BITS (PIXEL_BITS)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[g]),
         .in_ready  (chain_ready[g]),
         .in_ctrl   (chain_ctrl[g]),
         .in_c      (chain_c[g]),
         .in_pmax   (chain_pmax[g]),
         .in_lim    (chain_lim[g]),
         .in_pa     (chain_pa[g]),
         .in_pb     (chain_pb[g]),
         .in_en     (chain_en[g]),
         .in_best   (chain_best[g]),
         .in_res    (chain_res[g]),
         .out_valid (chain_valid[g+1]),
         .out_ready (chain_ready[g+1]),
         .out_ctrl  (chain_ctrl[g+1]),
         .out_c     (chain_c[g+1]),
         .out_pmax  (chain_pmax[g+1]),
         .out_lim   (chain_lim[g+1]),
         .out_pa    (chain_pa[g+1]),
         .out_pb    (chain_pb[g+1]),
         .out_en    (chain_en[g+1]),
         .out_best  (chain_best[g+1]),
         .out_res   (chain_res[g+1])
      );
   end

   // keep the chosen value within the limit of the centre pixel
   always_comb begin
      lo_b   = (chain_c[NP] > chain_lim[NP]) ? chain_c[NP] - chain_lim[NP] : '0;
      up_sum = {1'b0, chain_c[NP]} + {1'b0, chain_lim[NP]};
      hi_b   = (up_sum > {1'b0, chain_pmax[NP]}) ? chain_pmax[NP] : up_sum[W-1:0];
      if (chain_res[NP] < lo_b) begin
         clamped = lo_b;
      end else if (chain_res[NP] > hi_b) begin
         clamped = hi_b;
      end else begin
         clamped = chain_res[NP];
      end
      // border words and unused planes or rules pass the centre through
      pixel_in = chain_ctrl[NP].bypass ? chain_c[NP] : clamped;
   end

   assign out_ready       = !rsp_tvalid_ff || rsp_tready;
   assign chain_ready[NP] = out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_tvalid_ff <= chain_valid[NP];
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready && chain_valid[NP]) begin
         out_pixel_ff  <= pixel_in;
         out_pmax_ff   <= chain_pmax[NP];
         out_c_ff      <= chain_c[NP];
         out_bypass_ff <= chain_ctrl[NP].bypass;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = 16'(out_pixel_ff);

   // result never exceeds the pixel range of its own word
   a_pixel_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid_ff |-> (out_pixel_ff <= out_pmax_ff))
      else $error("output pixel above pixel max");

   // pass-through words give the centre pixel unchanged
   a_bypass_center: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid_ff && out_bypass_ff) |-> (out_pixel_ff == out_c_ff))
      else $error("pass-through word altered");

   // an empty output register frees the whole chain
   a_chain_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid_ff |-> req_tready)
      else $error("request stalled with empty output");

   // a stalled result word is not replaced
   a_hold_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid_ff && !rsp_tready) |=> $stable(out_pixel_ff))
      else $error("stalled result changed");

endmodule

### tb/tb.sv
`timescale 1ns / 1ps

module tb;

   // run limit in clock cycles, far above the slowest legal run
   localparam int CYCLE_LIMIT = 600000;
   localparam int PHASES = 10;
   localparam int WORDS_PER_PHASE = 105;

   // pair orders, index into the 27 pixels: previous 0..8, current 9..17, next 18..26
   // min-diff rule: temporal pairs first, then current diagonals, vertical, horizontal
   localparam logic [0:12][4:0] MIN_A = {5'd18, 5'd20, 5'd24, 5'd26, 5'd25, 5'd19, 5'd21,
                                         5'd23, 5'd22, 5'd9, 5'd11, 5'd10, 5'd12};
   localparam logic [0:12][4:0] MIN_B = {5'd8, 5'd6, 5'd2, 5'd0, 5'd1, 5'd7, 5'd5,
                                         5'd3, 5'd4, 5'd17, 5'd15, 5'd16, 5'd14};
   // weighted rules: current diagonals, vertical, horizontal, then temporal pairs
   localparam logic [0:12][4:0] WGT_A = {5'd9, 5'd15, 5'd16, 5'd14, 5'd18, 5'd20, 5'd24,
                                         5'd26, 5'd25, 5'd19, 5'd21, 5'd23, 5'd22};
   localparam logic [0:12][4:0] WGT_B = {5'd17, 5'd11, 5'd10, 5'd12, 5'd8, 5'd6, 5'd2,
                                         5'd0, 5'd1, 5'd7, 5'd5, 5'd3, 5'd4};
   localparam int MIN_HPAIR = 12;
   localparam int WGT_HPAIR = 3;

   typedef enum logic {ROW_PIXEL, ROW_REG} row_kind_type;

   // one row of the directed stimulus table
   typedef struct {
      row_kind_type kind;
      logic [431:0] win;
      logic [2:0]   user;
      logic [2:0]   idx;
      logic [7:0]   val;
      bit           typed;    // expected pixel typed in below
      logic [15:0]  want;
   } stim_row_type;

   logic         clock;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   // prev_top, prev_mid, prev_bot, cur_top, cur_mid, cur_bot, next_top, next_mid, next_bot
   logic [431:0] req_tdata = '0;
   // plane_index [1:0], copy_through [2]
   logic [2:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   // out_pixel [15:0]
   logic [15:0]  rsp_tdata;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [2:0]   csr_index = '0;
   logic [7:0]   csr_data = '0;

   // typed expectation riding along with the request word
   logic         req_typed = 1'b0;
   logic [15:0]  req_want = '0;

   // shadow copy of the block's registers
   logic [7:0]   lim_cfg [3];
   logic [2:0]   mode_cfg [3];
   logic         skip_cfg;
   logic [4:0]   depth_cfg;

   logic [15:0]  pixel_q [$];    // filtered pixels still to come
   logic [15:0]  want_pixel;
   int           n_sent = 0;     // request words accepted
   int           n_done = 0;     // response words matched against an expectation
   int           n_err = 0;
   int           cycles = 0;
   int           stall_mode = 0;
   int           hold_left = 0;
   logic         hold_level = 1'b1;
   stim_row_type steps [$];

   spatiotemporal_degrain_pixel_top #(.PIXEL_BITS(16)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // lowest bit of pixel i: row i/3 of the 9 packed rows, left pixel on top
   function automatic int px_lsb(input int i);
      return 48 * (i / 3) + 32 - 16 * (i % 3);
   endfunction

   // largest pixel value, bit depth held to 8..16
   function automatic int full_scale();
      int bd;
      bd = depth_cfg;
      if (bd < 8) bd = 8;
      if (bd > 16) bd = 16;
      return (1 << bd) - 1;
   endfunction

   // filtered pixel for one request word under the shadow registers
   function automatic logic [15:0] degrain_pixel(input logic [431:0] win,
                                                 input logic [2:0] user);
      int px [27];
      int i, pm, c, lim, res, best, lo, hi, a, b, d, w, v, pl, md, lo_b, hi_b;
      pm = full_scale();
      for (i = 0; i < 27; i++) px[i] = win[px_lsb(i) +: 16] & pm;
      c = px[13];
      pl = user[1:0];
      // border copy, missing plane, or no rule for the mode: center as is
      if (user[2] || pl == dgm_pkg::PLANE_NONE) return c[15:0];
      md = mode_cfg[pl];
      if (md > dgm_pkg::MODE_DIST_ONLY) return c[15:0];
      lim = (pm * lim_cfg[pl]) / dgm_pkg::LIMIT_SCALE;
      if (md == dgm_pkg::MODE_MIN_DIFF) begin
         best = 65535;
         lo = 0;
         hi = 65535;
         for (i = 0; i < 13; i++) begin
            if (i == MIN_HPAIR && skip_cfg) continue;
            a = px[MIN_A[i]];
            b = px[MIN_B[i]];
            d = a > b ? a - b : b - a;
            // ties go to the later pair
            if (d <= best) begin
               best = d;
               lo = a < b ? a : b;
               hi = a > b ? a : b;
            end
         end
         res = c < hi ? c : hi;
         res = res > lo ? res : lo;
      end else begin
         best = 65535;
         res = 0;
         for (i = 0; i < 13; i++) begin
            if (i == WGT_HPAIR && skip_cfg) continue;
            a = px[WGT_A[i]];
            b = px[WGT_B[i]];
            hi = a > b ? a : b;
            lo = a < b ? a : b;
            v = c < hi ? c : hi;
            v = v > lo ? v : lo;
            w = (lo - c) > 0 ? lo - c : 0;
            w = (c - hi) > w ? c - hi : w;
            if (md != dgm_pkg::MODE_DIST_ONLY) begin
               d = hi - lo;
               if (md == dgm_pkg::MODE_DIST_X2) w = w + w;
               else if (md == dgm_pkg::MODE_DIFF_X2) d = d * 2;
               else if (md == dgm_pkg::MODE_DIFF_X4) d = d * 4;
               w = (w + d) < pm ? w + d : pm;
            end
            if (w <= best) begin
               best = w;
               res = v;
            end
         end
      end
      // stay within the scaled limit of the center
      lo_b = (c - lim) > 0 ? c - lim : 0;
      hi_b = (c + lim) < pm ? c + lim : pm;
      res = res < hi_b ? res : hi_b;
      res = res > lo_b ? res : lo_b;
      return res[15:0];
   endfunction

   // window with pixel i = base + stepv * (i % period)
   function automatic logic [431:0] pattern(input logic [15:0] base, input logic [15:0] stepv,
                                            input int period);
      logic [431:0] w;
      int i;
      w = '0;
      for (i = 0; i < 27; i++) w[px_lsb(i) +: 16] = 16'(base + stepv * (i % period));
      return w;
   endfunction

   function automatic logic [431:0] with_center(input logic [431:0] win, input logic [15:0] c);
      logic [431:0] w;
      w = win;
      w[px_lsb(13) +: 16] = c;
      return w;
   endfunction

   task automatic add_pixel(input logic [431:0] win, input logic [2:0] user, input bit typed,
                            input logic [15:0] want);
      stim_row_type r;
      r.kind = ROW_PIXEL;
      r.win = win;
      r.user = user;
      r.idx = '0;
      r.val = '0;
      r.typed = typed;
      r.want = want;
      steps.push_back(r);
   endtask

   task automatic add_reg(input logic [2:0] idx, input logic [7:0] val);
      stim_row_type r;
      r.kind = ROW_REG;
      r.win = '0;
      r.user = '0;
      r.idx = idx;
      r.val = val;
      r.typed = 1'b0;
      r.want = '0;
      steps.push_back(r);
   endtask

   // directed table: starts from the reset registers (limit 4, diff x4, 8 bits)
   task automatic build_steps();
      add_pixel(pattern(16'h0000, 16'h0, 1), 3'b000, 1, 16'h0000);
      add_pixel(pattern(16'hFFFF, 16'h0, 1), 3'b000, 1, 16'h00FF);
      add_pixel(with_center(pattern(16'h0000, 16'h0, 1), 16'd200), 3'b000, 0, '0);
      // pixels above the 8-bit range get masked
      add_pixel(with_center(pattern(16'h1234, 16'h0, 1), 16'hAB80), 3'b001, 0, '0);
      add_pixel(pattern(16'd5, 16'd7, 27), 3'b010, 0, '0);
      // border copy and the plane with no registers give the center
      add_pixel(with_center(pattern(16'h0000, 16'h0, 1), 16'hFFFF), 3'b100, 1, 16'h00FF);
      add_pixel(pattern(16'd100, 16'hFFFD, 27), {1'b0, dgm_pkg::PLANE_NONE}, 1, 16'd61);
      // zero limit pins the center, full limit lets the pair value through
      add_reg(dgm_pkg::REG_LIMIT0, 8'd0);
      add_pixel(pattern(16'd0, 16'd9, 27), 3'b000, 1, 16'd117);
      add_reg(dgm_pkg::REG_LIMIT0, 8'd255);
      add_pixel(with_center(pattern(16'd10, 16'h0, 1), 16'd100), 3'b000, 0, '0);
      add_pixel(pattern(16'd3, 16'd11, 27), 3'b000, 0, '0);
      add_reg(dgm_pkg::REG_MODE0, {5'b0, dgm_pkg::MODE_MIN_DIFF});
      add_pixel(pattern(16'd200, 16'hFFF9, 27), 3'b000, 0, '0);
      add_pixel(with_center(pattern(16'd50, 16'h0, 1), 16'd60), 3'b000, 0, '0);
      // equal differences with different spans, the later pair must win
      add_pixel(pattern(16'd30, 16'd8, 2), 3'b000, 0, '0);
      add_reg(dgm_pkg::REG_LIMIT1, 8'd255);
      add_reg(dgm_pkg::REG_LIMIT2, 8'd128);
      add_reg(dgm_pkg::REG_MODE1, {5'b0, dgm_pkg::MODE_DIFF_X2});
      add_reg(dgm_pkg::REG_MODE2, {5'b0, dgm_pkg::MODE_DIFF_X1});
      add_pixel(pattern(16'd40, 16'd5, 27), 3'b001, 0, '0);
      add_pixel(pattern(16'd40, 16'd5, 27), 3'b010, 0, '0);
      add_reg(dgm_pkg::REG_MODE1, {5'b0, dgm_pkg::MODE_DIST_X2});
      add_reg(dgm_pkg::REG_MODE2, {5'b0, dgm_pkg::MODE_DIST_ONLY});
      add_pixel(pattern(16'd90, 16'hFFFB, 27), 3'b001, 0, '0);
      add_pixel(pattern(16'd90, 16'd6, 2), 3'b010, 0, '0);
      // modes six and seven have no rule
      add_reg(dgm_pkg::REG_MODE0, 8'd6);
      add_pixel(pattern(16'd7, 16'd3, 27), 3'b000, 1, 16'd46);
      add_reg(dgm_pkg::REG_MODE0, 8'd7);
      add_pixel(pattern(16'd1, 16'd1, 27), 3'b000, 1, 16'd14);
      add_reg(dgm_pkg::REG_MODE0, {5'b0, dgm_pkg::MODE_MIN_DIFF});
      add_reg(dgm_pkg::REG_SKIP, 8'd1);
      add_pixel(with_center(pattern(16'd20, 16'h0, 1), 16'd30), 3'b000, 0, '0);
      add_pixel(pattern(16'd2, 16'd13, 27), 3'b000, 0, '0);
      add_reg(dgm_pkg::REG_BIT_DEPTH, 8'd16);
      add_pixel(pattern(16'hFFFF, 16'h0, 1), 3'b000, 1, 16'hFFFF);
      add_pixel(pattern(16'hF000, 16'h0555, 27), 3'b000, 0, '0);
      // bit depth saturates at both ends
      add_reg(dgm_pkg::REG_BIT_DEPTH, 8'd0);
      add_pixel(pattern(16'hFFFF, 16'h0, 1), 3'b000, 1, 16'h00FF);
      add_reg(dgm_pkg::REG_BIT_DEPTH, 8'd31);
      add_pixel(with_center(pattern(16'h0000, 16'h0, 1), 16'hFFFF), 3'b100, 1, 16'hFFFF);
   endtask

   // hand one word to the block, valid stays high afterwards
   task automatic send_word(input logic [431:0] win, input logic [2:0] user, input bit typed,
                            input logic [15:0] want);
      req_tdata <= win;
      req_tuser <= user;
      req_typed <= typed;
      req_want <= want;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      n_sent++;
   endtask

   // one register write, valid stays high for a following write
   task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
      csr_index <= idx;
      csr_data <= val;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
   endtask

   // stop sending and wait until every filtered pixel is back
   task automatic settle();
      if (req_tvalid) req_tvalid <= 1'b0;
      while (n_done < n_sent) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   function automatic logic [7:0] pick_limit();
      case ($urandom_range(0, 3))
         0: return 8'd0;
         1: return 8'd255;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // mostly real rules, now and then six or seven; junk in the unused bits
   function automatic logic [7:0] pick_mode();
      logic [2:0] m;
      m = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
      return (8'($urandom) & 8'hF8) | {5'b0, m};
   endfunction

   function automatic logic [7:0] pick_depth();
      logic [4:0] d;
      d = ($urandom_range(0, 7) == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(8, 16));
      return (8'($urandom) & 8'hE0) | {3'b0, d};
   endfunction

   // random window: mostly pixels close to one level, some fully random
   task automatic make_item(output logic [431:0] win, output logic [2:0] user);
      int i, flavor, base, amp, pm;
      logic [15:0] v;
      pm = full_scale();
      flavor = $urandom_range(0, 7);
      base = $urandom_range(0, pm);
      amp = (1 << $urandom_range(0, 10)) - 1;
      win = '0;
      for (i = 0; i < 27; i++) begin
         if (flavor == 0 || $urandom_range(0, 15) == 0) begin
            v = 16'($urandom_range(0, 65535));
         end else begin
            v = 16'(base + $urandom_range(0, 2 * amp) - amp);
            // stray bits above the bit depth
            if (flavor == 1) v = v | 16'($urandom_range(0, 65535) & ~pm);
         end
         win[px_lsb(i) +: 16] = v;
      end
      user[1:0] = ($urandom_range(0, 7) == 0) ? dgm_pkg::PLANE_NONE
                                               : 2'($urandom_range(0, 2));
      user[2] = ($urandom_range(0, 9) == 0);
   endtask

   // response side back-pressure, pattern picked per phase
   always @(posedge clock) begin
      case (stall_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= ($urandom_range(0, 3) != 0);
         2: rsp_tready <= ((cycles % 7) < 4);
         default: begin
            // long runs of ready and stalled
            if (hold_left == 0) begin
               hold_left = $urandom_range(1, 24);
               hold_level = ~hold_level;
            end
            hold_left--;
            rsp_tready <= hold_level;
         end
      endcase
   end

   // scoreboard: checks responses, predicts accepted words, tracks register writes
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb: done, errors");
         $finish;
      end else if (reset) begin
         lim_cfg[0] = dgm_pkg::LIMIT_RESET;
         lim_cfg[1] = dgm_pkg::LIMIT_RESET;
         lim_cfg[2] = dgm_pkg::LIMIT_RESET;
         mode_cfg[0] = dgm_pkg::MODE_RESET;
         mode_cfg[1] = dgm_pkg::MODE_RESET;
         mode_cfg[2] = dgm_pkg::MODE_RESET;
         skip_cfg = 1'b0;
         depth_cfg = dgm_pkg::BIT_DEPTH_RESET;
      end else begin
         // responses first: the block's output is registered
         if (rsp_tvalid && rsp_tready) begin
            if (pixel_q.size() == 0) begin
               n_err++;
               $error("out_pixel: expected none, got %0h", rsp_tdata);
            end else begin
               want_pixel = pixel_q.pop_front();
               n_done++;
               if (rsp_tdata !== want_pixel) begin
                  n_err++;
                  $error("out_pixel: expected %0h, got %0h", want_pixel, rsp_tdata);
               end
            end
         end
         if (req_tvalid && req_tready)
            pixel_q.push_back(req_typed ? req_want : degrain_pixel(req_tdata, req_tuser));
         if (csr_valid && csr_ready) begin
            case (csr_index)
               dgm_pkg::REG_LIMIT0:    lim_cfg[0] = csr_data;
               dgm_pkg::REG_LIMIT1:    lim_cfg[1] = csr_data;
               dgm_pkg::REG_LIMIT2:    lim_cfg[2] = csr_data;
               dgm_pkg::REG_MODE0:     mode_cfg[0] = csr_data[2:0];
               dgm_pkg::REG_MODE1:     mode_cfg[1] = csr_data[2:0];
               dgm_pkg::REG_MODE2:     mode_cfg[2] = csr_data[2:0];
               dgm_pkg::REG_SKIP:      skip_cfg = csr_data[0];
               dgm_pkg::REG_BIT_DEPTH: depth_cfg = csr_data[4:0];
               default: ;
            endcase
         end
      end
   end

   initial begin
      logic [431:0] win;
      logic [2:0]   user;
      int           i, ph, j, burst_left, gap, gap_max;
      bit           prev_reg;

      build_steps();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table; registers only change with nothing in flight
      prev_reg = 1'b0;
      for (i = 0; i < steps.size(); i++) begin
         if (steps[i].kind == ROW_REG) begin
            if (!prev_reg) settle();
            write_reg(steps[i].idx, steps[i].val);
            prev_reg = 1'b1;
         end else begin
            if (csr_valid) csr_valid <= 1'b0;
            send_word(steps[i].win, steps[i].user, steps[i].typed, steps[i].want);
            prev_reg = 1'b0;
         end
      end

      // random phases, each under a new register setting
      for (ph = 0; ph < PHASES; ph++) begin
         settle();
         case (ph)
            0: begin
               // everything at the top
               write_reg(dgm_pkg::REG_LIMIT0, 8'd255);
               write_reg(dgm_pkg::REG_LIMIT1, 8'd255);
               write_reg(dgm_pkg::REG_LIMIT2, 8'd255);
               write_reg(dgm_pkg::REG_MODE0, {5'b0, dgm_pkg::MODE_MIN_DIFF});
               write_reg(dgm_pkg::REG_MODE1, {5'b0, dgm_pkg::MODE_DIFF_X4});
               write_reg(dgm_pkg::REG_MODE2, {5'b0, dgm_pkg::MODE_DIST_ONLY});
               write_reg(dgm_pkg::REG_SKIP, 8'd0);
               write_reg(dgm_pkg::REG_BIT_DEPTH, 8'd16);
            end
            1: begin
               // everything at the bottom
               write_reg(dgm_pkg::REG_LIMIT0, 8'd0);
               write_reg(dgm_pkg::REG_LIMIT1, 8'd1);
               write_reg(dgm_pkg::REG_LIMIT2, 8'd0);
               write_reg(dgm_pkg::REG_MODE0, {5'b0, dgm_pkg::MODE_DIFF_X1});
               write_reg(dgm_pkg::REG_MODE1, {5'b0, dgm_pkg::MODE_MIN_DIFF});
               write_reg(dgm_pkg::REG_MODE2, {5'b0, dgm_pkg::MODE_DIST_X2});
               write_reg(dgm_pkg::REG_SKIP, 8'd1);
               write_reg(dgm_pkg::REG_BIT_DEPTH, 8'd8);
            end
            default: begin
               write_reg(dgm_pkg::REG_LIMIT0, pick_limit());
               write_reg(dgm_pkg::REG_LIMIT1, pick_limit());
               write_reg(dgm_pkg::REG_LIMIT2, pick_limit());
               write_reg(dgm_pkg::REG_MODE0, pick_mode());
               write_reg(dgm_pkg::REG_MODE1, pick_mode());
               write_reg(dgm_pkg::REG_MODE2, pick_mode());
               write_reg(dgm_pkg::REG_SKIP, 8'($urandom));
               write_reg(dgm_pkg::REG_BIT_DEPTH, pick_depth());
            end
         endcase
         csr_valid <= 1'b0;
         stall_mode = ph % 4;
         // some phases stream back to back with no gaps at all
         gap_max = (ph % 3 == 1) ? 0 : 8;
         burst_left = 0;
         for (j = 0; j < WORDS_PER_PHASE; j++) begin
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 32);
               gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
               if (gap > 0 && req_tvalid) begin
                  req_tvalid <= 1'b0;
                  repeat (gap) @(posedge clock);
               end
            end
            burst_left--;
            make_item(win, user);
            send_word(win, user, 1'b0, '0);
         end
      end

      // drain, then give the pipeline time to show any stray word
      req_tvalid <= 1'b0;
      while (n_done < n_sent) @(posedge clock);
      repeat (40) @(posedge clock);
      if (n_err == 0 && pixel_q.size() == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule
